// ===== src/ffd_pkg.sv =====
// Shared types and constants for the free-fall detector.
// Used by ffd_iter and freefall_detect_integrate; depends on nothing.
`default_nettype none
package ffd_pkg;

  localparam int DW = 100;
  localparam int STEP_W = 6;

  localparam logic [19:0] GRAVITY_Q16 = 20'd642253;
  localparam logic [16:0] ONE_G_Q12 = 17'd4096;
  localparam logic [21:0] IDEAL_SCALE = 22'd3211264;
  localparam logic [9:0] PCT_SCALE = 10'd1000;

  localparam logic [STEP_W-1:0] SQRT_STEPS = 6'd16;
  localparam logic [STEP_W-1:0] DV_STEPS = 6'd24;
  localparam logic [STEP_W-1:0] DP_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] PCT_STEPS = 6'd13;

  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_TOL = 2'd1;
  localparam logic [1:0] REG_RATE = 2'd2;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

endpackage
`default_nettype wire

// ===== src/freefall_detect_integrate.sv =====
// Free-fall detector top level: config registers, sequencer, result register.
// Depends on ffd_pkg, ffd_mul and ffd_iter.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_accel_x, in_accel_y, in_accel_z
//   out      output     out_valid/out_ready  out_fall_distance, out_fall_samples,
//                                            out_percent_less
//   cfg      input      APB psel/penable     paddr[3:2] register, pwdata
//
// An item outside a fall takes only the squares and the window test; one inside a
// fall also runs the one-bit-a-cycle iterative unit (16 square-root steps, then
// 24 + 32 division steps). The item that ends a fall also runs the states S_P1
// to S_P9, 13 division steps and the result load.
// Synchronous active-low reset clears the fall state and loads register defaults.
// A pending result holds the block at its last step until out_ready.
`default_nettype none
module freefall_detect_integrate #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] in_accel_x,
  input  wire logic signed [15:0] in_accel_y,
  input  wire logic signed [15:0] in_accel_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_fall_distance,
  output logic        [15:0]      out_fall_samples,
  output logic signed [10:0]      out_percent_less,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int DW = ffd_pkg::DW;

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_UP, S_LO, S_TEST, S_SQRT, S_DVA, S_DVMUL,
    S_DV, S_DP, S_DPW, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9,
    S_PW, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] center_r, tol_r;
  logic [15:0] rate_r, rate_eff;
  logic in_fall_r, in_fall_nxt, falling_r, falling_nxt, tneg_r, tneg_nxt;
  logic signed [31:0] vel_r, vel_nxt, pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [16:0] ax_r, ay_r, az_r;
  logic [31:0] sum_r, sum_nxt, upsq_r, upsq_nxt;
  logic [41:0] p1_r, p1_nxt;
  logic [31:0] r2_r, r2_nxt;
  logic [63:0] cc_r, cc_nxt;
  logic [DW-1:0] num_r, num_nxt, den_r, den_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] dist_r, dist_nxt;
  logic [15:0] samp_r, samp_nxt;
  logic signed [10:0] pct_r, pct_nxt, pct_calc_r, pct_calc_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  ffd_pkg::iter_cmd_t cmd;
  logic [DW-1:0] it_num, it_den, it_rem;
  logic it_busy, it_done;
  logic [31:0] it_quo;
  logic [15:0] it_root;

  logic [15:0] upper;
  logic signed [15:0] lower;
  logic signed [16:0] tval;
  logic [16:0] tabs;
  logic [31:0] vel_abs, pos_abs, cnt32;
  logic signed [33:0] step34, sum34;
  logic [12:0] qv;
  logic frac;
  logic signed [14:0] pct15;
  logic emit_go, wr_en;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] e;
    e = 17'(v);
    return v[15] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) return v[31:0];
    return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
  endfunction

  ffd_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(prod));

  ffd_iter u_iter (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .num_i(it_num), .den_i(it_den),
    .busy(it_busy), .done(it_done), .rem_o(it_rem), .quo_o(it_quo), .root_o(it_root)
  );

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign rate_eff = (rate_r == 16'd0) ? 16'd1 : rate_r;

  always_comb begin
    case (paddr[3:2])
      ffd_pkg::REG_CENTER: prdata = 32'(center_r);
      ffd_pkg::REG_TOL:    prdata = 32'(tol_r);
      ffd_pkg::REG_RATE:   prdata = 32'(rate_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= 15'd410;
      tol_r <= 15'd819;
      rate_r <= 16'd500;
    end else if (wr_en) begin
      case (paddr[3:2])
        ffd_pkg::REG_CENTER: center_r <= pwdata[14:0];
        ffd_pkg::REG_TOL:    tol_r <= pwdata[14:0];
        ffd_pkg::REG_RATE:   rate_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign upper = 16'(center_r) + 16'(tol_r);
  assign lower = $signed(16'(center_r)) - $signed(16'(tol_r));
  assign tval = $signed(ffd_pkg::ONE_G_Q12) - $signed({1'b0, it_root});
  assign tabs = tval[16] ? 17'(-tval) : 17'(tval);
  assign vel_abs = vel_r[31] ? 32'(-33'(vel_r)) : 32'(vel_r);
  assign pos_abs = pos_r[31] ? 32'(-33'(pos_r)) : 32'(pos_r);
  assign cnt32 = 32'(count_r);
  assign emit_go = !out_valid_r || out_ready;

  always_comb begin
    qv = it_quo[12] ? 13'd4096 : {1'b0, it_quo[11:0]};
    frac = !it_quo[12] && (it_rem != '0);
    if (pos_r[31]) begin
      pct15 = 15'sd100 + $signed({2'b00, qv});
    end else if (frac && qv <= 13'd99) begin
      pct15 = 15'sd99 - $signed({2'b00, qv});
    end else begin
      pct15 = 15'sd100 - $signed({2'b00, qv});
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_fall_nxt = in_fall_r;
    falling_nxt = falling_r;
    tneg_nxt = tneg_r;
    vel_nxt = vel_r;
    pos_nxt = pos_r;
    count_nxt = count_r;
    sum_nxt = sum_r;
    upsq_nxt = upsq_r;
    p1_nxt = p1_r;
    r2_nxt = r2_r;
    cc_nxt = cc_r;
    num_nxt = num_r;
    den_nxt = den_r;
    pct_calc_nxt = pct_calc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dist_nxt = dist_r;
    samp_nxt = samp_r;
    pct_nxt = pct_r;
    mul_a = '0;
    mul_b = '0;
    cmd = '0;
    it_num = '0;
    it_den = '0;
    step34 = '0;
    sum34 = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SQX;
      end
      S_SQX: begin
        mul_a = 32'(ax_r);
        mul_b = 32'(ax_r);
        state_nxt = S_SQY;
      end
      S_SQY: begin
        sum_nxt = prod[31:0];
        mul_a = 32'(ay_r);
        mul_b = 32'(ay_r);
        state_nxt = S_SQZ;
      end
      S_SQZ: begin
        sum_nxt = sum_r + prod[31:0];
        mul_a = 32'(az_r);
        mul_b = 32'(az_r);
        state_nxt = S_UP;
      end
      S_UP: begin
        sum_nxt = sum_r + prod[31:0];
        mul_a = 32'(upper);
        mul_b = 32'(upper);
        state_nxt = S_LO;
      end
      S_LO: begin
        upsq_nxt = prod[31:0];
        mul_a = 32'(lower[14:0]);
        mul_b = 32'(lower[14:0]);
        state_nxt = S_TEST;
      end
      S_TEST: begin
        falling_nxt = (sum_r < upsq_r) && (lower[15] || sum_r > prod[31:0]);
        if (!in_fall_r) begin
          if (falling_nxt) begin
            in_fall_nxt = 1'b1;
            vel_nxt = '0;
            pos_nxt = '0;
            count_nxt = '0;
          end
          state_nxt = S_IDLE;
        end else begin
          cmd.start = 1'b1;
          cmd.sqrt_mode = 1'b1;
          cmd.steps = ffd_pkg::SQRT_STEPS;
          it_num = DW'(sum_r);
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (it_done) state_nxt = S_DVA;
      end
      S_DVA: begin
        tneg_nxt = tval[16];
        mul_a = 32'(tabs);
        mul_b = 32'(ffd_pkg::GRAVITY_Q16);
        state_nxt = S_DVMUL;
      end
      S_DVMUL: begin
        cmd.start = 1'b1;
        cmd.steps = ffd_pkg::DV_STEPS;
        it_num = DW'(prod);
        it_den = DW'(rate_eff) << 35;
        state_nxt = S_DV;
      end
      S_DV: begin
        if (it_done) begin
          step34 = tneg_r ? -34'(it_quo) : 34'(it_quo);
          sum34 = 34'(vel_r) + step34;
          vel_nxt = sat32(sum34);
          state_nxt = S_DP;
        end
      end
      S_DP: begin
        cmd.start = 1'b1;
        cmd.steps = ffd_pkg::DP_STEPS;
        it_num = DW'(vel_abs);
        it_den = DW'(rate_eff) << 31;
        state_nxt = S_DPW;
      end
      S_DPW: begin
        if (it_done) begin
          step34 = vel_r[31] ? -34'(it_quo) : 34'(it_quo);
          sum34 = 34'(pos_r) + step34;
          pos_nxt = sat32(sum34);
          if (count_r != '1) count_nxt = count_r + 1'b1;
          if (falling_r) begin
            state_nxt = S_IDLE;
          end else begin
            in_fall_nxt = 1'b0;
            pct_calc_nxt = '0;
            state_nxt = (count_nxt == '0) ? S_EMIT : S_P1;
          end
        end
      end
      S_P1: begin
        mul_a = pos_abs;
        mul_b = 32'(ffd_pkg::PCT_SCALE);
        state_nxt = S_P2;
      end
      S_P2: begin
        p1_nxt = prod[41:0];
        mul_a = 32'(rate_eff);
        mul_b = 32'(rate_eff);
        state_nxt = S_P3;
      end
      S_P3: begin
        r2_nxt = prod[31:0];
        mul_a = p1_r[31:0];
        mul_b = prod[31:0];
        state_nxt = S_P4;
      end
      S_P4: begin
        num_nxt = DW'(prod);
        mul_a = 32'(p1_r[41:32]);
        mul_b = r2_r;
        state_nxt = S_P5;
      end
      S_P5: begin
        num_nxt = num_r + (DW'(prod) << 32);
        mul_a = cnt32;
        mul_b = cnt32;
        state_nxt = S_P6;
      end
      S_P6: begin
        cc_nxt = prod;
        mul_a = prod[31:0];
        mul_b = 32'(ffd_pkg::IDEAL_SCALE);
        state_nxt = S_P7;
      end
      S_P7: begin
        den_nxt = DW'(prod);
        mul_a = cc_r[63:32];
        mul_b = 32'(ffd_pkg::IDEAL_SCALE);
        state_nxt = S_P8;
      end
      S_P8: begin
        den_nxt = den_r + (DW'(prod) << 32);
        state_nxt = S_P9;
      end
      S_P9: begin
        cmd.start = 1'b1;
        cmd.steps = ffd_pkg::PCT_STEPS;
        it_num = num_r;
        it_den = den_r << 12;
        state_nxt = S_PW;
      end
      S_PW: begin
        if (it_done) begin
          if (pct15 > 15'sd1000) pct_calc_nxt = 11'sd1000;
          else if (pct15 < -15'sd1000) pct_calc_nxt = -11'sd1000;
          else pct_calc_nxt = pct15[10:0];
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          dist_nxt = pos_r;
          samp_nxt = (cnt32 > 32'd65535) ? 16'hFFFF : cnt32[15:0];
          pct_nxt = pct_calc_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_fall_r <= 1'b0;
      vel_r <= '0;
      pos_r <= '0;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      in_fall_r <= in_fall_nxt;
      vel_r <= vel_nxt;
      pos_r <= pos_nxt;
      count_r <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ax_r <= abs16(in_accel_x);
      ay_r <= abs16(in_accel_y);
      az_r <= abs16(in_accel_z);
    end
    falling_r <= falling_nxt;
    tneg_r <= tneg_nxt;
    sum_r <= sum_nxt;
    upsq_r <= upsq_nxt;
    p1_r <= p1_nxt;
    r2_r <= r2_nxt;
    cc_r <= cc_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    pct_calc_r <= pct_calc_nxt;
    dist_r <= dist_nxt;
    samp_r <= samp_nxt;
    pct_r <= pct_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_fall_distance = dist_r;
  assign out_fall_samples = samp_r;
  assign out_percent_less = pct_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted during processing");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !it_busy)
    else $error("iterative unit restarted while busy");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT && emit_go |=> out_valid && !in_fall_r)
    else $error("result not loaded at end of fall");

endmodule
`default_nettype wire

// ===== src/ffd_mul.sv =====
// Registered 32x32 unsigned multiplier shared by the sequencer.
// No dependencies.
`default_nettype none
module ffd_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule
`default_nettype wire

// ===== src/ffd_iter.sv =====
// Iterative restoring divider and integer square root, one step a cycle.
// Depends on ffd_pkg.
`default_nettype none
module ffd_iter (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ffd_pkg::iter_cmd_t    cmd,
  input  wire logic [ffd_pkg::DW-1:0] num_i,
  input  wire logic [ffd_pkg::DW-1:0] den_i,
  output logic                       busy,
  output logic                       done,
  output logic [ffd_pkg::DW-1:0]     rem_o,
  output logic [31:0]                quo_o,
  output logic [15:0]                root_o
);

  logic [ffd_pkg::DW-1:0] r_r, r_nxt, d_r, d_nxt, operand;
  logic [31:0] b_r, q_r;
  logic [ffd_pkg::STEP_W-1:0] cnt_r;
  logic busy_r, done_r, mode_r, ge;

  always_comb begin
    operand = mode_r ? d_r + ffd_pkg::DW'(b_r) : d_r;
    ge = r_r >= operand;
    r_nxt = ge ? r_r - operand : r_r;
    if (mode_r) begin
      d_nxt = ge ? (d_r >> 1) + ffd_pkg::DW'(b_r) : d_r >> 1;
    end else begin
      d_nxt = d_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r <= cmd.steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == ffd_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= cmd.sqrt_mode;
      r_r <= num_i;
      d_r <= cmd.sqrt_mode ? '0 : den_i;
      b_r <= 32'h4000_0000;
      q_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      d_r <= d_nxt;
      b_r <= b_r >> 2;
      q_r <= {q_r[30:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem_o = r_r;
  assign quo_o = q_r;
  assign root_o = d_r[15:0];

endmodule
`default_nettype wire
